@@ hw/rtl/sem_pkg.sv @@
package sem_pkg;

   // item field widths
   localparam int SAMPLE_W    = 8;
   localparam int EDGE_W      = 8;
   localparam int OUT_ROW_W   = 12;
   localparam int OUT_COL_W   = 11;
   localparam int OUT_CHAN_W  = 2;

   // register file
   localparam int CSR_INDEX_W     = 2;
   localparam int CSR_DATA_W      = 13;
   localparam int IMAGE_WIDTH_W   = 12;
   localparam int IMAGE_HEIGHT_W  = 13;
   localparam int CHANNEL_COUNT_W = 3;

   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

   localparam logic [IMAGE_WIDTH_W-1:0]   IMAGE_WIDTH_RST   = 12'd640;
   localparam logic [IMAGE_HEIGHT_W-1:0]  IMAGE_HEIGHT_RST  = 13'd480;
   localparam logic [CHANNEL_COUNT_W-1:0] CHANNEL_COUNT_RST = 3'd3;

   // datapath widths: a weighted column sum of three samples is at most 4 * 255
   localparam int GRAD_W     = 10;
   localparam int SQ_W       = 2 * GRAD_W + 1;
   localparam int ROOT_W     = EDGE_W;
   localparam int ROOT_SQ_W  = 2 * ROOT_W;
   localparam int ROOT_BIT_W = $clog2(ROOT_W);

   localparam logic [ROOT_W-1:0] ROOT_SAT = '1;

   // item sequencer
   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_READ = 7'b0000010,
      ST_GRAD = 7'b0000100,
      ST_SQ_X = 7'b0001000,
      ST_SQ_Y = 7'b0010000,
      ST_ROOT = 7'b0100000,
      ST_EMIT = 7'b1000000
   } state_type;

endpackage

@@ hw/rtl/sobel_edge_magnitude_unit.sv @@
// Channel   Direction  Handshake              Payload
// req_      in         req_valid/req_ready    req_sample
// rsp_      out        rsp_valid/rsp_ready    rsp_edge_value, rsp_out_row, rsp_out_col,
//                                             rsp_out_channel, rsp_frame_end
// csr_      in         csr_write_enable       csr_index, csr_write_data
//
// An item goes through accept and the line store read-modify-write, then each result it
// releases goes through gradients, squaring of both gradients on one shared multiplier,
// a bit-serial square root (cut short when saturated) and the hand-off cycle.
// Interior items release one result; a new item is accepted only once the last is handed off.
// Reset is synchronous; it clears counters, registers and the window, not the line stores.
// A stalled result sits in the output register; the next item is accepted meanwhile.
module sobel_edge_magnitude_unit import sem_pkg::*; #(
   parameter int MAX_WIDTH    = 2048,
   parameter int MAX_HEIGHT   = 4096,
   parameter int MAX_CHANNELS = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [SAMPLE_W-1:0]        req_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [EDGE_W-1:0]          rsp_edge_value,
   output logic [OUT_ROW_W-1:0]       rsp_out_row,
   output logic [OUT_COL_W-1:0]       rsp_out_col,
   output logic [OUT_CHAN_W-1:0]      rsp_out_channel,
   output logic                       rsp_frame_end,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_write_data
);

   localparam int DEPTH = MAX_WIDTH * MAX_CHANNELS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int CHW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

   // configuration
   logic [IMAGE_WIDTH_W-1:0]   image_width_ff;
   logic [IMAGE_HEIGHT_W-1:0]  image_height_ff;
   logic [CHANNEL_COUNT_W-1:0] channel_count_ff;
   logic                       csr_hit;
   logic [XW-1:0]              last_col;
   logic [YW-1:0]              last_row;
   logic [CHW-1:0]             last_chan;

   // stream position of the next item
   logic [XW-1:0]  col_ff, col_in;
   logic [YW-1:0]  row_ff, row_in;
   logic [CHW-1:0] chan_ff, chan_in;
   logic [AW-1:0]  idx_ff, idx_in;
   logic           req_accept;

   // item snapshot
   logic [SAMPLE_W-1:0] sample_ff;
   logic [XW-1:0]       item_x_ff;
   logic [YW-1:0]       item_y_ff;
   logic [CHW-1:0]      item_c_ff;
   logic [AW-1:0]       item_idx_ff;
   logic                item_last_col_ff;
   logic                item_last_row_ff;
   logic                item_last_chan_ff;
   logic                has_prev_col;
   logic                has_prev_row;
   logic                any_result;

   // line stores and their read data
   logic [SAMPLE_W-1:0] line_store_upper_mem [DEPTH];
   logic [SAMPLE_W-1:0] line_store_lower_mem [DEPTH];
   logic [SAMPLE_W-1:0] upper_rd_ff;
   logic [SAMPLE_W-1:0] lower_rd_ff;

   // window columns: [channel][age][rows back]
   logic [SAMPLE_W-1:0] window_ff [MAX_CHANNELS][2][3];
   logic [SAMPLE_W-1:0] prev1_ff [3];
   logic [SAMPLE_W-1:0] prev2_ff [3];

   // result sequencing and arithmetic
   state_type           state_ff, state_in;
   logic                sel_col_cur_ff;
   logic                sel_row_cur_ff;
   logic [1:0]          col_dist [3];
   logic [1:0]          row_dist [3];
   logic [SAMPLE_W-1:0] col_val [3][3];
   logic [SAMPLE_W-1:0] tap [3][3];
   logic [GRAD_W-1:0]   sum_left, sum_right, sum_top, sum_bot;
   logic [GRAD_W-1:0]   gx_mag_ff, gy_mag_ff;
   logic [GRAD_W-1:0]   sq_operand;
   logic [2*GRAD_W-1:0] sq_prod;
   logic [SQ_W-1:0]     acc_ff;
   logic [ROOT_W-1:0]   root_ff;
   logic [ROOT_BIT_W-1:0] bit_ff;
   logic [ROOT_W-1:0]   cand;
   logic [ROOT_SQ_W-1:0] cand_sq;
   logic                root_sat;
   logic                emit_go;
   logic                more_rows;
   logic                more_cols;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [EDGE_W-1:0]     rsp_edge_value_ff;
   logic [OUT_ROW_W-1:0]  rsp_out_row_ff;
   logic [OUT_COL_W-1:0]  rsp_out_col_ff;
   logic [OUT_CHAN_W-1:0] rsp_out_channel_ff;
   logic                  rsp_frame_end_ff;
   logic [XW-1:0]         res_col;
   logic [YW-1:0]         res_row;

   assign req_ready  = (state_ff == ST_IDLE) && !reset;
   assign req_accept = req_valid && req_ready;

   // register writes
   assign csr_hit = csr_write_enable && (csr_index == REG_IMAGE_WIDTH ||
                                         csr_index == REG_IMAGE_HEIGHT ||
                                         csr_index == REG_CHANNEL_COUNT);

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff   <= IMAGE_WIDTH_RST;
         image_height_ff  <= IMAGE_HEIGHT_RST;
         channel_count_ff <= CHANNEL_COUNT_RST;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_IMAGE_WIDTH:   image_width_ff   <= csr_write_data[IMAGE_WIDTH_W-1:0];
            REG_IMAGE_HEIGHT:  image_height_ff  <= csr_write_data[IMAGE_HEIGHT_W-1:0];
            REG_CHANNEL_COUNT: channel_count_ff <= csr_write_data[CHANNEL_COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp the frame geometry into the supported range
   always_comb begin
      if (image_width_ff == '0) begin
         last_col = '0;
      end else if (image_width_ff > MAX_WIDTH) begin
         last_col = XW'(MAX_WIDTH - 1);
      end else begin
         last_col = XW'(image_width_ff - 1'b1);
      end
      if (image_height_ff == '0) begin
         last_row = '0;
      end else if (image_height_ff > MAX_HEIGHT) begin
         last_row = YW'(MAX_HEIGHT - 1);
      end else begin
         last_row = YW'(image_height_ff - 1'b1);
      end
      if (channel_count_ff == '0) begin
         last_chan = '0;
      end else if (channel_count_ff > MAX_CHANNELS) begin
         last_chan = CHW'(MAX_CHANNELS - 1);
      end else begin
         last_chan = CHW'(channel_count_ff - 1'b1);
      end
   end

   // advance the raster position; any register write restarts the frame
   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      chan_in = chan_ff;
      idx_in  = idx_ff;
      if (csr_hit) begin
         col_in  = '0;
         row_in  = '0;
         chan_in = '0;
         idx_in  = '0;
      end else if (req_accept) begin
         if (chan_ff == last_chan) begin
            chan_in = '0;
            if (col_ff == last_col) begin
               col_in = '0;
               idx_in = '0;
               row_in = (row_ff == last_row) ? '0 : row_ff + 1'b1;
            end else begin
               col_in = col_ff + 1'b1;
               idx_in = idx_ff + 1'b1;
            end
         end else begin
            chan_in = chan_ff + 1'b1;
            idx_in  = idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         chan_ff <= '0;
         idx_ff  <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         chan_ff <= chan_in;
         idx_ff  <= idx_in;
      end
   end

   // capture the item and its position
   always_ff @(posedge clock) begin
      if (req_accept) begin
         sample_ff         <= req_sample;
         item_x_ff         <= col_ff;
         item_y_ff         <= row_ff;
         item_c_ff         <= chan_ff;
         item_idx_ff       <= idx_ff;
         item_last_col_ff  <= (col_ff == last_col);
         item_last_row_ff  <= (row_ff == last_row);
         item_last_chan_ff <= (chan_ff == last_chan);
      end
   end

   assign has_prev_col = (item_x_ff != '0);
   assign has_prev_row = (item_y_ff != '0);
   assign any_result   = (has_prev_col || item_last_col_ff) && (has_prev_row || item_last_row_ff);

   // line stores: read on accept, shift the column down in the next cycle (ST_READ)
   always_ff @(posedge clock) begin
      if (state_ff == ST_READ) begin
         line_store_upper_mem[item_idx_ff] <= lower_rd_ff;
         line_store_lower_mem[item_idx_ff] <= sample_ff;
      end
      if (req_accept) begin
         upper_rd_ff <= line_store_upper_mem[idx_ff];
         lower_rd_ff <= line_store_lower_mem[idx_ff];
      end
   end

   // window: take out the channel's two older columns and push the new one
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
            for (int a = 0; a < 2; a++) begin
               for (int r = 0; r < 3; r++) begin
                  window_ff[ch][a][r] <= '0;
               end
            end
         end
      end else if (state_ff == ST_READ) begin
         for (int r = 0; r < 3; r++) begin
            window_ff[item_c_ff][1][r] <= window_ff[item_c_ff][0][r];
         end
         window_ff[item_c_ff][0][0] <= sample_ff;
         window_ff[item_c_ff][0][1] <= lower_rd_ff;
         window_ff[item_c_ff][0][2] <= upper_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_READ) begin
         for (int r = 0; r < 3; r++) begin
            prev1_ff[r] <= window_ff[item_c_ff][0][r];
            prev2_ff[r] <= window_ff[item_c_ff][1][r];
         end
      end
   end

   // pick the 3x3 neighborhood with replicated borders
   always_comb begin
      col_val[0][0] = sample_ff;
      col_val[0][1] = lower_rd_ff;
      col_val[0][2] = upper_rd_ff;
      for (int r = 0; r < 3; r++) begin
         col_val[1][r] = prev1_ff[r];
         col_val[2][r] = prev2_ff[r];
      end
      if (sel_col_cur_ff) begin
         col_dist[0] = has_prev_col ? 2'd1 : 2'd0;
         col_dist[1] = 2'd0;
         col_dist[2] = 2'd0;
      end else begin
         col_dist[0] = (item_x_ff == XW'(1)) ? 2'd1 : 2'd2;
         col_dist[1] = 2'd1;
         col_dist[2] = 2'd0;
      end
      if (sel_row_cur_ff) begin
         row_dist[0] = has_prev_row ? 2'd1 : 2'd0;
         row_dist[1] = 2'd0;
         row_dist[2] = 2'd0;
      end else begin
         row_dist[0] = (item_y_ff == YW'(1)) ? 2'd1 : 2'd2;
         row_dist[1] = 2'd1;
         row_dist[2] = 2'd0;
      end
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            tap[i][j] = col_val[col_dist[j]][row_dist[i]];
         end
      end
   end

   // weighted edge sums of the window, 1-2-1 along each border
   assign sum_left  = GRAD_W'(tap[0][0]) + GRAD_W'({tap[1][0], 1'b0}) + GRAD_W'(tap[2][0]);
   assign sum_right = GRAD_W'(tap[0][2]) + GRAD_W'({tap[1][2], 1'b0}) + GRAD_W'(tap[2][2]);
   assign sum_top   = GRAD_W'(tap[0][0]) + GRAD_W'({tap[0][1], 1'b0}) + GRAD_W'(tap[0][2]);
   assign sum_bot   = GRAD_W'(tap[2][0]) + GRAD_W'({tap[2][1], 1'b0}) + GRAD_W'(tap[2][2]);

   // shared squaring multiplier and bit-serial root
   assign sq_operand = (state_ff == ST_SQ_X) ? gx_mag_ff : gy_mag_ff;
   assign sq_prod    = sq_operand * sq_operand;
   assign root_sat   = |acc_ff[SQ_W-1:ROOT_SQ_W];
   assign cand       = root_ff | (ROOT_W'(1) << bit_ff);
   assign cand_sq    = cand * cand;

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_GRAD: begin
            gx_mag_ff <= (sum_right >= sum_left) ? sum_right - sum_left : sum_left - sum_right;
            gy_mag_ff <= (sum_bot >= sum_top) ? sum_bot - sum_top : sum_top - sum_bot;
         end
         ST_SQ_X: begin
            acc_ff <= SQ_W'(sq_prod);
         end
         ST_SQ_Y: begin
            acc_ff  <= acc_ff + SQ_W'(sq_prod);
            root_ff <= '0;
            bit_ff  <= ROOT_BIT_W'(ROOT_W - 1);
         end
         ST_ROOT: begin
            if (root_sat) begin
               root_ff <= ROOT_SAT;
            end else begin
               if (cand_sq <= acc_ff[ROOT_SQ_W-1:0]) begin
                  root_ff <= cand;
               end
               bit_ff <= bit_ff - 1'b1;
            end
         end
         default: ;
      endcase
   end

   // result walk: by column, then by row
   assign emit_go   = !rsp_valid_ff || rsp_ready;
   assign more_rows = !sel_row_cur_ff && item_last_row_ff;
   assign more_cols = !sel_col_cur_ff && item_last_col_ff;

   always_ff @(posedge clock) begin
      if (state_ff == ST_READ) begin
         sel_col_cur_ff <= !has_prev_col;
         sel_row_cur_ff <= !has_prev_row;
      end else if (state_ff == ST_EMIT && emit_go) begin
         if (more_rows) begin
            sel_row_cur_ff <= 1'b1;
         end else if (more_cols) begin
            sel_col_cur_ff <= 1'b1;
            sel_row_cur_ff <= !has_prev_row;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = any_result ? ST_GRAD : ST_IDLE;
         end
         ST_GRAD: state_in = ST_SQ_X;
         ST_SQ_X: state_in = ST_SQ_Y;
         ST_SQ_Y: state_in = ST_ROOT;
         ST_ROOT: begin
            if (root_sat || bit_ff == '0) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (emit_go) begin
               state_in = (more_rows || more_cols) ? ST_GRAD : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // output register: load in the hand-off cycle, drop when taken
   assign res_col = sel_col_cur_ff ? item_x_ff : item_x_ff - 1'b1;
   assign res_row = sel_row_cur_ff ? item_y_ff : item_y_ff - 1'b1;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (state_ff == ST_EMIT && emit_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_EMIT && emit_go) begin
         rsp_edge_value_ff  <= root_ff;
         rsp_out_row_ff     <= OUT_ROW_W'(res_row);
         rsp_out_col_ff     <= OUT_COL_W'(res_col);
         rsp_out_channel_ff <= OUT_CHAN_W'(item_c_ff);
         rsp_frame_end_ff   <= sel_col_cur_ff && item_last_col_ff && sel_row_cur_ff &&
                               item_last_row_ff && item_last_chan_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_edge_value  = rsp_edge_value_ff;
   assign rsp_out_row     = rsp_out_row_ff;
   assign rsp_out_col     = rsp_out_col_ff;
   assign rsp_out_channel = rsp_out_channel_ff;
   assign rsp_frame_end   = rsp_frame_end_ff;

`ifndef SYNTHESIS
   a_read_after_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> $past(req_valid && req_ready))
      else $error("line store write-back without a preceding item");

   a_position_in_frame: assert property (@(posedge clock) disable iff (reset)
      (col_ff <= last_col) && (row_ff <= last_row) && (chan_ff <= last_chan))
      else $error("raster position outside the configured frame");

   a_row_start_index: assert property (@(posedge clock) disable iff (reset)
      (col_ff == '0 && chan_ff == '0) |-> (idx_ff == '0))
      else $error("line store index not at zero at row start");

   a_result_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("result raised outside the hand-off cycle");
`endif

endmodule

@@ tb/sv/sobel_edge_magnitude_unit_test.sv @@
`timescale 1ns / 1ps

module sobel_edge_magnitude_unit_test;
   import sem_pkg::*;

   localparam int STORE_DEPTH    = 8192;
   localparam int LIMIT_W        = 2048;
   localparam int LIMIT_H        = 4096;
   localparam int LIMIT_CH       = 4;
   localparam int RANDOM_ITEMS   = 230;
   localparam int PHASE_CAP      = 64;
   localparam int EXTREME_ITEMS  = 24;
   localparam int SETTLE_CYCLES  = 64;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SCRIPT_ROWS    = 31;

   // index past the register list; the block must ignore writes to it
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE = 2'd3;

   typedef enum logic {ROW_SAMPLE, ROW_WRITE} script_op_type;
   typedef enum logic [1:0] {PIX_UNIFORM, PIX_LOW, PIX_BINARY, PIX_RAMP} pixel_style_type;

   typedef struct packed {
      script_op_type          op;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  data;
      logic [SAMPLE_W-1:0]    sample;
      logic                   typed;
      logic [EDGE_W-1:0]      typed_edge;
   } script_row_type;

   typedef struct packed {
      logic [EDGE_W-1:0]     edge_value;
      logic [OUT_ROW_W-1:0]  row;
      logic [OUT_COL_W-1:0]  col;
      logic [OUT_CHAN_W-1:0] chan;
      logic                  frame_end;
   } edge_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [SAMPLE_W-1:0]    req_sample = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [EDGE_W-1:0]      rsp_edge_value;
   logic [OUT_ROW_W-1:0]   rsp_out_row;
   logic [OUT_COL_W-1:0]   rsp_out_col;
   logic [OUT_CHAN_W-1:0]  rsp_out_channel;
   logic                   rsp_frame_end;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data = '0;

   // predictor copy of registers and stream state
   logic [IMAGE_WIDTH_W-1:0]   cfg_width    = IMAGE_WIDTH_RST;
   logic [IMAGE_HEIGHT_W-1:0]  cfg_height   = IMAGE_HEIGHT_RST;
   logic [CHANNEL_COUNT_W-1:0] cfg_chans    = CHANNEL_COUNT_RST;
   bit   [SAMPLE_W-1:0]        older_row  [0:STORE_DEPTH-1];
   bit   [SAMPLE_W-1:0]        prior_row  [0:STORE_DEPTH-1];
   bit   [SAMPLE_W-1:0]        recent_cols [0:23];
   int                         next_col  = 0;
   int                         next_row  = 0;
   int                         next_chan = 0;

   edge_result_type step_edges [$];
   edge_result_type awaited_edges [$];
   edge_result_type arrived_want;

   int errors       = 0;
   int quiet_cycles = 0;
   int ready_hold   = 0;
   bit steady       = 1'b0;

   // directed rows: reset config, saturation, single-pixel frames, clamped registers
   script_row_type direct_script [0:SCRIPT_ROWS-1] = '{
      '{ROW_SAMPLE, REG_IMAGE_WIDTH,   13'd0,    8'h00, 1'b0, 8'd0},
      '{ROW_SAMPLE, REG_IMAGE_WIDTH,   13'd0,    8'hFF, 1'b0, 8'd0},
      '{ROW_SAMPLE, REG_IMAGE_WIDTH,   13'd0,    8'h5A, 1'b0, 8'd0},
      '{ROW_WRITE,  REG_IMAGE_WIDTH,   13'd2,    8'h00, 1'b0, 8'd0},
      '{ROW_WRITE,  REG_IMAGE_HEIGHT,  13'd2,    8'h00, 1'b0, 8'd0},
      '{ROW_WRITE,  REG_CHANNEL_COUNT, 13'd1,    8'h00, 1'b0, 8'd0},
      '{ROW_SAMPLE, REG_IMAGE_WIDTH,   13'd0,    8'h00, 1'b0, 8'd0},
      '{ROW_SAMPLE, REG_IMAGE_WIDTH,   13'd0,    8'hFF, 1'b0, 8'd0},
      '{ROW_SAMPLE, REG_IMAGE_WIDTH,   13'd0,    8'h00, 1'b0, 8'd0},
      '{ROW_SAMPLE, REG_IMAGE_WIDTH,   13'd0,    8'hFF, 1'b1, 8'd255},
      '{ROW_WRITE,  REG_IMAGE_WIDTH,   13'd0,    8'h00, 1'b0, 8'd0},
      '{ROW_WRITE,  REG_IMAGE_HEIGHT,  13'd0,    8'h00, 1'b0, 8'd0},
      '{ROW_SAMPLE, REG_IMAGE_WIDTH,   13'd0,    8'hFF, 1'b1, 8'd0},
      '{ROW_SAMPLE, REG_IMAGE_WIDTH,   13'd0,    8'h00, 1'b1, 8'd0},
      '{ROW_WRITE,  REG_CHANNEL_COUNT, 13'd7,    8'h00, 1'b0, 8'd0},
      '{ROW_SAMPLE, REG_IMAGE_WIDTH,   13'd0,    8'h01, 1'b1, 8'd0},
      '{ROW_SAMPLE, REG_IMAGE_WIDTH,   13'd0,    8'h02, 1'b1, 8'd0},
      '{ROW_WRITE,  REG_SPARE,         13'h1FFF, 8'h00, 1'b0, 8'd0},
      '{ROW_SAMPLE, REG_IMAGE_WIDTH,   13'd0,    8'h03, 1'b1, 8'd0},
      '{ROW_SAMPLE, REG_IMAGE_WIDTH,   13'd0,    8'h04, 1'b1, 8'd0},
      '{ROW_WRITE,  REG_IMAGE_WIDTH,   13'd3,    8'h00, 1'b0, 8'd0},
      '{ROW_WRITE,  REG_IMAGE_HEIGHT,  13'd1,    8'h00, 1'b0, 8'd0},
      '{ROW_WRITE,  REG_CHANNEL_COUNT, 13'd1,    8'h00, 1'b0, 8'd0},
      '{ROW_SAMPLE, REG_IMAGE_WIDTH,   13'd0,    8'd0,  1'b0, 8'd0},
      '{ROW_SAMPLE, REG_IMAGE_WIDTH,   13'd0,    8'd40, 1'b0, 8'd0},
      '{ROW_SAMPLE, REG_IMAGE_WIDTH,   13'd0,    8'd100, 1'b0, 8'd0},
      '{ROW_WRITE,  REG_IMAGE_WIDTH,   13'd1,    8'h00, 1'b0, 8'd0},
      '{ROW_WRITE,  REG_IMAGE_HEIGHT,  13'd3,    8'h00, 1'b0, 8'd0},
      '{ROW_SAMPLE, REG_IMAGE_WIDTH,   13'd0,    8'd0,  1'b0, 8'd0},
      '{ROW_SAMPLE, REG_IMAGE_WIDTH,   13'd0,    8'd10, 1'b0, 8'd0},
      '{ROW_SAMPLE, REG_IMAGE_WIDTH,   13'd0,    8'd30, 1'b0, 8'd0}
   };

   sobel_edge_magnitude_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_edge_value   (rsp_edge_value),
      .rsp_out_row      (rsp_out_row),
      .rsp_out_col      (rsp_out_col),
      .rsp_out_channel  (rsp_out_channel),
      .rsp_frame_end    (rsp_frame_end),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int clamp_range(int v, int lo, int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // replicate the border: a neighbor outside [0, limit-1] becomes the nearest one inside
   function automatic int neighbor(int pos, int delta, int limit);
      if (delta < 0) return (pos == 0) ? 0 : pos - 1;
      if (delta > 0) return (pos + 1 >= limit) ? limit - 1 : pos + 1;
      return pos;
   endfunction

   // mostly no gap, some short ones, a few long ones
   function automatic int pick_gap();
      int roll;
      if (steady) return 0;
      roll = $urandom_range(99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   function automatic logic [EDGE_W-1:0] gradient_magnitude(int r, int xc, int y, int x,
         int w, int h, int c, logic [2:0][SAMPLE_W-1:0] column);
      int gx, gy, rd, cd, v, sum, root;
      gx = 0;
      gy = 0;
      for (int dy = -1; dy <= 1; dy++) begin
         rd = y - neighbor(r, dy, h);
         if (rd > 2) rd = 2;
         for (int dx = -1; dx <= 1; dx++) begin
            cd = x - neighbor(xc, dx, w);
            if (cd > 2) cd = 2;
            // column 0 is the incoming one, 1 and 2 come from the held columns
            if (cd == 0) v = column[rd];
            else v = recent_cols[((c % 4) * 6 + (cd - 1) * 3 + rd) % 24];
            // Sobel weights: 2 on the center row or column, 1 at the corners
            gx += dx * ((dy == 0) ? 2 : 1) * v;
            gy += dy * ((dx == 0) ? 2 : 1) * v;
         end
      end
      sum = gx * gx + gy * gy;
      if (sum >= 65536) return '1;
      root = 0;
      while ((root + 1) * (root + 1) <= sum) root++;
      return root[EDGE_W-1:0];
   endfunction

   // advance the stream by one sample and collect the edges it releases
   function automatic void predict_sobel_step(logic [SAMPLE_W-1:0] sample);
      int w, h, nc, x, y, c, idx, ncols, nrows;
      int cols [2];
      int rows [2];
      logic [2:0][SAMPLE_W-1:0] column;
      edge_result_type res;
      w  = clamp_range(int'(cfg_width), 1, LIMIT_W);
      h  = clamp_range(int'(cfg_height), 1, LIMIT_H);
      nc = clamp_range(int'(cfg_chans), 1, LIMIT_CH);
      x  = (next_col >= w) ? w - 1 : next_col;
      y  = (next_row >= h) ? h - 1 : next_row;
      c  = (next_chan >= nc) ? nc - 1 : next_chan;
      idx = (x * nc + c) % STORE_DEPTH;
      column[0] = sample;
      column[1] = prior_row[idx];
      column[2] = older_row[idx];

      ncols = 0;
      nrows = 0;
      if (x >= 1) begin
         cols[ncols] = x - 1;
         ncols++;
      end
      if (x == w - 1) begin
         cols[ncols] = x;
         ncols++;
      end
      if (y >= 1) begin
         rows[nrows] = y - 1;
         nrows++;
      end
      if (y == h - 1) begin
         rows[nrows] = y;
         nrows++;
      end

      for (int i = 0; i < ncols; i++) begin
         for (int j = 0; j < nrows; j++) begin
            res.edge_value = gradient_magnitude(rows[j], cols[i], y, x, w, h, c, column);
            res.row        = OUT_ROW_W'(rows[j]);
            res.col        = OUT_COL_W'(cols[i]);
            res.chan       = OUT_CHAN_W'(c);
            res.frame_end  = (cols[i] == w - 1 && rows[j] == h - 1 && c == nc - 1);
            step_edges.push_back(res);
         end
      end

      // shift line stores and the column window
      older_row[idx] = prior_row[idx];
      prior_row[idx] = sample;
      for (int i = 0; i < 3; i++) begin
         recent_cols[c * 6 + 3 + i] = recent_cols[c * 6 + i];
         recent_cols[c * 6 + i]     = column[i];
      end

      c++;
      if (c >= nc) begin
         c = 0;
         x++;
         if (x >= w) begin
            x = 0;
            y++;
            if (y >= h) y = 0;
         end
      end
      next_chan = c;
      next_col  = x;
      next_row  = y;
   endfunction

   // any write to a listed register restarts the frame
   function automatic void apply_register(logic [CSR_INDEX_W-1:0] index,
                                          logic [CSR_DATA_W-1:0] data);
      case (index)
         REG_IMAGE_WIDTH:   cfg_width  = data[IMAGE_WIDTH_W-1:0];
         REG_IMAGE_HEIGHT:  cfg_height = data[IMAGE_HEIGHT_W-1:0];
         REG_CHANNEL_COUNT: cfg_chans  = data[CHANNEL_COUNT_W-1:0];
         default:           return;
      endcase
      next_col  = 0;
      next_row  = 0;
      next_chan = 0;
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endfunction

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(posedge clock);
      apply_register(index, data);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // hold off until every edge is out and the block has gone quiet
   task automatic drain_block();
      while (awaited_edges.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // offer one item, hold it until accepted, then queue the edges it releases
   task automatic send_sample(input logic [SAMPLE_W-1:0] sample, input logic typed,
                              input logic [EDGE_W-1:0] typed_edge);
      int gap;
      edge_result_type res;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= sample;
      do @(posedge clock); while (!req_ready);
      step_edges.delete();
      predict_sobel_step(sample);
      foreach (step_edges[k]) begin
         res = step_edges[k];
         if (typed) res.edge_value = typed_edge;
         awaited_edges.push_back(res);
      end
   endtask

   task automatic run_phase(input logic [CSR_DATA_W-1:0] width_raw,
                            input logic [CSR_DATA_W-1:0] height_raw,
                            input logic [CSR_DATA_W-1:0] chan_raw,
                            input int count, input pixel_style_type style);
      int ramp;
      logic [SAMPLE_W-1:0] pixel;
      drain_block();
      write_register(REG_IMAGE_WIDTH, width_raw);
      write_register(REG_IMAGE_HEIGHT, height_raw);
      write_register(REG_CHANNEL_COUNT, chan_raw);
      ramp = $urandom_range(255);
      for (int n = 0; n < count; n++) begin
         case (style)
            PIX_UNIFORM: pixel = SAMPLE_W'($urandom_range(255));
            PIX_LOW:     pixel = SAMPLE_W'($urandom_range(31));
            PIX_BINARY:  pixel = ($urandom_range(1) == 1) ? 8'hFF : 8'h00;
            default: begin
               ramp  = (ramp + $urandom_range(3)) % 256;
               pixel = SAMPLE_W'(ramp);
            end
         endcase
         send_sample(pixel, 1'b0, '0);
      end
      req_valid <= 1'b0;
   endtask

   // result side: random stalls
   always @(posedge clock) begin
      if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
         rsp_ready  <= 1'b0;
      end else begin
         ready_hold <= pick_gap();
         rsp_ready  <= 1'b1;
      end
   end

   // compare each accepted result with the oldest expected edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_edges.size() == 0) begin
            $display("%0t ns: unexpected result, expected none, actual edge %0d row %0d col %0d",
                     $time, rsp_edge_value, rsp_out_row, rsp_out_col);
            errors++;
         end else begin
            arrived_want = awaited_edges.pop_front();
            check_field("edge_value", int'(arrived_want.edge_value), int'(rsp_edge_value));
            check_field("out_row", int'(arrived_want.row), int'(rsp_out_row));
            check_field("out_col", int'(arrived_want.col), int'(rsp_out_col));
            check_field("out_channel", int'(arrived_want.chan), int'(rsp_out_channel));
            check_field("frame_end", int'(arrived_want.frame_end), int'(rsp_frame_end));
         end
      end
   end

   // watchdog: count cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t ns: no handshake for %0d cycles, %0d results outstanding",
                  $time, WATCHDOG_LIMIT, awaited_edges.size());
         $display("sobel_edge_magnitude_unit verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int random_items, roll, count, frame;
      logic [CSR_DATA_W-1:0] width_raw, height_raw, chan_raw;
      bit in_burst;
      random_items = 0;
      in_burst     = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed part
      foreach (direct_script[k]) begin
         if (direct_script[k].op == ROW_WRITE) begin
            if (in_burst) begin
               req_valid <= 1'b0;
               drain_block();
               in_burst = 1'b0;
            end
            write_register(direct_script[k].index, direct_script[k].data);
         end else begin
            send_sample(direct_script[k].sample, direct_script[k].typed,
                        direct_script[k].typed_edge);
            in_burst = 1'b1;
         end
      end
      if (in_burst) req_valid <= 1'b0;

      // random frames: mostly whole small frames, some cut short by a restart
      while (random_items < RANDOM_ITEMS) begin
         roll = $urandom_range(99);
         if (roll < 78) width_raw = CSR_DATA_W'($urandom_range(8, 1));
         else if (roll < 95) width_raw = CSR_DATA_W'($urandom_range(24, 9));
         else width_raw = '0;
         roll = $urandom_range(99);
         if (roll < 85) height_raw = CSR_DATA_W'($urandom_range(5, 1));
         else if (roll < 93) height_raw = '0;
         else height_raw = CSR_DATA_W'($urandom_range(10, 6));
         if ($urandom_range(99) < 70) chan_raw = CSR_DATA_W'($urandom_range(4, 1));
         else chan_raw = CSR_DATA_W'($urandom_range(7));
         frame = clamp_range(int'(width_raw), 1, LIMIT_W)
                 * clamp_range(int'(height_raw), 1, LIMIT_H)
                 * clamp_range(int'(chan_raw), 1, LIMIT_CH);
         if ($urandom_range(4) == 0) count = $urandom_range(frame, 1);
         else count = frame * $urandom_range(2, 1);
         if (count > PHASE_CAP) count = PHASE_CAP;
         steady = ($urandom_range(3) == 0);
         run_phase(width_raw, height_raw, chan_raw, count,
                   pixel_style_type'($urandom_range(3)));
         random_items += count;
      end

      // widest row and tallest column, the start of one frame each
      steady = ($urandom_range(1) == 0);
      run_phase(13'h1FFF, 13'd1, 13'd1, EXTREME_ITEMS, PIX_UNIFORM);
      steady = ($urandom_range(1) == 0);
      run_phase(13'd1, 13'd4096, 13'd1, EXTREME_ITEMS, PIX_LOW);

      drain_block();
      if (errors == 0) begin
         $display("sobel_edge_magnitude_unit verification clean");
      end else begin
         $display("sobel_edge_magnitude_unit verification failed");
      end
      $finish;
   end

endmodule
